FILE: rtl/tmtw_pkg.sv
// Shared types, field widths and character codes for the text-mode terminal writer.
package tmtw_pkg;

	localparam int ACTION_W   = 1;
	localparam int CHAR_W     = 8;
	localparam int INDEX_W    = 11;
	localparam int POSITION_W = 11;
	localparam int CELL_W     = 16;
	localparam int ATTR_W     = 8;

	localparam logic [ACTION_W-1:0] ACTION_PUT  = 1'b0;
	localparam logic [ACTION_W-1:0] ACTION_READ = 1'b1;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CHAR_W-1:0]   char_byte;
		logic [INDEX_W-1:0]  cell_index;
	} item_t;

	typedef struct packed {
		logic [POSITION_W-1:0] cursor_position;
		logic [CELL_W-1:0]     cell_data;
	} result_t;

	typedef logic [ATTR_W-1:0] attr_t;

	// Build one screen cell: attribute above character.
	function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
			input logic [CHAR_W-1:0] ch);
		return {attr, ch};
	endfunction

endpackage

FILE: rtl/tmtw_chan.sv
// Valid/ready channel carrying one word of a given payload type.
interface tmtw_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/text_mode_terminal_writer_core.sv
// Text screen with cursor: put, wrap, newline, scroll and cell read over one memory.
// Put without scroll: the result word is loaded at the accepting edge.
// Read: memory read at the accepting edge, then result register; one at a time.
// Scroll: one cell copied per cycle.
// Reset: cursor to 0, attribute to 0x0F; a clearing pass writes blanks to every cell
// before the first item is taken.
module text_mode_terminal_writer_core #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  logic clk,
	input  logic arst_n,
	tmtw_chan.sink   item,
	tmtw_chan.source result,
	tmtw_chan.sink   cfg
);

	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(SCREEN_COLUMNS);
	localparam int ROW_W      = $clog2(SCREEN_ROWS);

	localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(SCREEN_COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(SCREEN_COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(SCREEN_ROWS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_BLANK
	} state_t;

	state_t state_q;

	logic [tmtw_pkg::CELL_W-1:0] screen_mem [CELL_COUNT];

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] pos_q;
	tmtw_pkg::attr_t   attr_q;
	logic [ADDR_W-1:0] ptr_q;

	// Write stage
	logic                        wr_s1;
	logic [ADDR_W-1:0]           wa_s1;
	logic [tmtw_pkg::CELL_W-1:0] wd_s1;
	logic                        wsel_rd_s1;

	// Read path
	logic [tmtw_pkg::CELL_W-1:0] rd_data_q;
	logic                        fwd_s1;
	logic [tmtw_pkg::CELL_W-1:0] fwd_data_s1;
	logic                        oor_s1;

	// Output register
	logic                            out_valid_q;
	logic [tmtw_pkg::POSITION_W-1:0] out_pos_q;
	logic [tmtw_pkg::CELL_W-1:0]     out_data_q;

	logic                        item_acc;
	logic                        is_put;
	logic                        is_nl;
	logic                        in_range;
	logic                        step_row;
	logic                        do_scroll;
	logic                        rd_en;
	logic [ADDR_W-1:0]           rd_addr;
	logic [ADDR_W-1:0]           next_row_pos;
	logic [tmtw_pkg::CELL_W-1:0] wdata;

	// Handshakes
	assign item.ready   = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign item_acc     = item.valid && item.ready;
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data.cursor_position = out_pos_q;
	assign result.data.cell_data       = out_data_q;

	// Decode the word and the cursor step
	assign is_put    = (item.data.action == tmtw_pkg::ACTION_PUT);
	assign is_nl     = (item.data.char_byte == tmtw_pkg::NEWLINE_CODE);
	assign in_range  = (int'(item.data.cell_index) < CELL_COUNT);
	assign step_row  = is_nl || (col_q == LAST_COL);
	assign do_scroll = step_row && (row_q == LAST_ROW);
	assign next_row_pos = pos_q - ADDR_W'(col_q) + COLS_A;

	// Select write data and read address
	assign wdata = wsel_rd_s1 ? rd_data_q : wd_s1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		if (state_q == ST_COPY) begin
			rd_en = 1'b1;
		end else if (item_acc && !is_put) begin
			rd_en   = 1'b1;
			rd_addr = in_range ? ADDR_W'(item.data.cell_index) : '0;
		end
	end

	// Screen memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			screen_mem[wa_s1] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= screen_mem[rd_addr];
		end
	end

	// Hold the attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tmtw_pkg::RESET_ATTR;
		end else if (cfg.valid && cfg.ready) begin
			attr_q <= cfg.data;
		end
	end

	// Sequencer: state, cursor, write stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			ptr_q       <= '0;
			wr_s1       <= 1'b0;
			wa_s1       <= '0;
			wd_s1       <= '0;
			wsel_rd_s1  <= 1'b0;
			fwd_s1      <= 1'b0;
			fwd_data_s1 <= '0;
			oor_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			out_pos_q   <= '0;
			out_data_q  <= '0;
		end else begin
			wr_s1 <= 1'b0;
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					wr_s1      <= 1'b1;
					wa_s1      <= ptr_q;
					wd_s1      <= tmtw_pkg::make_cell(tmtw_pkg::RESET_ATTR,
						tmtw_pkg::BLANK_CODE);
					wsel_rd_s1 <= 1'b0;
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (item_acc && is_put) begin
						// Write the character unless it is a newline
						if (!is_nl) begin
							wr_s1      <= 1'b1;
							wa_s1      <= pos_q;
							wd_s1      <= tmtw_pkg::make_cell(attr_q, item.data.char_byte);
							wsel_rd_s1 <= 1'b0;
						end
						if (do_scroll) begin
							row_q   <= LAST_ROW;
							col_q   <= '0;
							pos_q   <= LAST_ROW_BASE;
							ptr_q   <= COLS_A;
							state_q <= ST_COPY;
						end else if (step_row) begin
							row_q       <= row_q + 1'b1;
							col_q       <= '0;
							pos_q       <= next_row_pos;
							out_valid_q <= 1'b1;
							out_pos_q   <= tmtw_pkg::POSITION_W'(next_row_pos);
							out_data_q  <= '0;
						end else begin
							col_q       <= col_q + 1'b1;
							pos_q       <= pos_q + 1'b1;
							out_valid_q <= 1'b1;
							out_pos_q   <= tmtw_pkg::POSITION_W'(pos_q + 1'b1);
							out_data_q  <= '0;
						end
					end else if (item_acc) begin
						// Forward a write that lands on the same edge as the read
						fwd_s1      <= wr_s1 && (wa_s1 == rd_addr);
						fwd_data_s1 <= wdata;
						oor_s1      <= !in_range;
						state_q     <= ST_READ;
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					out_pos_q   <= tmtw_pkg::POSITION_W'(pos_q);
					if (oor_s1) begin
						out_data_q <= '0;
					end else if (fwd_s1) begin
						out_data_q <= fwd_data_s1;
					end else begin
						out_data_q <= rd_data_q;
					end
					state_q <= ST_IDLE;
				end
				ST_COPY: begin
					// Move each line up: read one row below, write next cycle
					wr_s1      <= 1'b1;
					wa_s1      <= ptr_q - COLS_A;
					wsel_rd_s1 <= 1'b1;
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= LAST_ROW_BASE;
						state_q <= ST_BLANK;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_BLANK: begin
					wr_s1      <= 1'b1;
					wa_s1      <= ptr_q;
					wd_s1      <= tmtw_pkg::make_cell(attr_q, tmtw_pkg::BLANK_CODE);
					wsel_rd_s1 <= 1'b0;
					if (ptr_q == LAST_ADDR) begin
						ptr_q       <= '0;
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_pos_q   <= tmtw_pkg::POSITION_W'(pos_q);
						out_data_q  <= '0;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Linear cursor tracks row and column
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) == int'(row_q) * SCREEN_COLUMNS + int'(col_q))
		else $error("linear cursor out of step with row and column");

	// Cursor stays on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) < SCREEN_ROWS) && (int'(col_q) < SCREEN_COLUMNS))
		else $error("cursor off the screen");

	// Copy writes stay behind the read pointer
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) && wr_s1 && wsel_rd_s1 |-> wa_s1 < ptr_q)
		else $error("copy write overtakes read");

	// A read always finds the output register free
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !out_valid_q)
		else $error("read result would overwrite pending word");

	// An accepted read goes to the read state
	assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && !is_put |=> (state_q == ST_READ))
		else $error("read word not followed by read state");

endmodule

FILE: dv/text_mode_terminal_writer_core_test.sv
// Self-checking testbench for the text-mode terminal writer core.
module text_mode_terminal_writer_core_test;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
	// a scroll writes every cell once, so allow that much after the last word
	localparam int SETTLE_CYCLES  = CELL_COUNT + 200;
	localparam int LONG_HOLD      = 600;
	localparam int CYCLE_LIMIT    = 12_000_000;
	localparam int SCRIPT_LEN     = 25;

	typedef struct packed {
		logic              pinned;
		tmtw_pkg::result_t value;
	} pin_t;

	typedef struct packed {
		tmtw_pkg::item_t   word;
		logic [7:0]        copies;
		logic              pinned;
		tmtw_pkg::result_t value;
	} script_row_t;

	// opening script: fixed values only where they follow at a glance
	localparam script_row_t OPENING_SCRIPT [SCRIPT_LEN] = '{
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd0},    8'd1,  1'b1, '{11'd0, 16'h0F20}},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd1999}, 8'd1,  1'b1, '{11'd0, 16'h0F20}},
		'{'{tmtw_pkg::ACTION_READ, 8'hFF, 11'd2000}, 8'd1,  1'b1, '{11'd0, 16'h0000}},
		'{'{tmtw_pkg::ACTION_READ, 8'h0A, 11'd2047}, 8'd1,  1'b1, '{11'd0, 16'h0000}},
		'{'{tmtw_pkg::ACTION_PUT,  8'h41, 11'd2047}, 8'd1,  1'b1, '{11'd1, 16'h0000}},
		'{'{tmtw_pkg::ACTION_PUT,  8'hFF, 11'd0},    8'd1,  1'b1, '{11'd2, 16'h0000}},
		'{'{tmtw_pkg::ACTION_PUT,  8'h00, 11'd0},    8'd1,  1'b1, '{11'd3, 16'h0000}},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd0},    8'd1,  1'b1, '{11'd3, 16'h0F41}},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd2},    8'd1,  1'b1, '{11'd3, 16'h0F00}},
		'{'{tmtw_pkg::ACTION_PUT,  8'h0A, 11'd0},    8'd1,  1'b1, '{11'd80, 16'h0000}},
		'{'{tmtw_pkg::ACTION_PUT,  8'h7E, 11'd0},    8'd80, 1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd159},  8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd160},  8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_PUT,  8'h0A, 11'd0},    8'd22, 1'b0, '0},
		'{'{tmtw_pkg::ACTION_PUT,  8'h5A, 11'd1234}, 8'd79, 1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd1998}, 8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_PUT,  8'h31, 11'd0},    8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd1919}, 8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd1920}, 8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_PUT,  8'h0A, 11'd0},    8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd1839}, 8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_PUT,  8'h80, 11'd0},    8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd1920}, 8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_PUT,  8'h7F, 11'd0},    8'd1,  1'b0, '0},
		'{'{tmtw_pkg::ACTION_READ, 8'h00, 11'd0},    8'd1,  1'b0, '0}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tmtw_chan #(.T(tmtw_pkg::item_t))   item_ch ();
	tmtw_chan #(.T(tmtw_pkg::result_t)) result_ch ();
	tmtw_chan #(.T(tmtw_pkg::attr_t))   cfg_ch ();

	text_mode_terminal_writer_core #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// shadow copy of the screen, cursor and attribute
	logic [tmtw_pkg::CELL_W-1:0] shadow_screen [CELL_COUNT];
	int unsigned                 shadow_row;
	int unsigned                 shadow_col;
	tmtw_pkg::attr_t             shadow_attr;

	tmtw_pkg::result_t awaited_results [$];
	pin_t              pin_plan [$];
	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;
	int unsigned tx_idle_pct   = 25;
	int unsigned rx_idle_pct   = 84;
	int unsigned hold_requests = 0;
	int unsigned hold_taken    = 0;
	int unsigned hold_left     = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one word to the shadow screen and return the result it should produce.
	function automatic tmtw_pkg::result_t apply_to_shadow_screen(input tmtw_pkg::item_t word);
		tmtw_pkg::result_t res;
		int unsigned       pos;
		res = '0;
		if (word.action == tmtw_pkg::ACTION_PUT) begin
			if (word.char_byte == tmtw_pkg::NEWLINE_CODE) begin
				shadow_col = 0;
				shadow_row++;
			end else begin
				pos = shadow_row * SCREEN_COLUMNS + shadow_col;
				if (pos < CELL_COUNT)
					shadow_screen[pos] = {shadow_attr, word.char_byte};
				shadow_col++;
				if (shadow_col >= SCREEN_COLUMNS) begin
					shadow_col = 0;
					shadow_row++;
				end
			end
			// scroll up one line and blank the bottom line
			if (shadow_row >= SCREEN_ROWS) begin
				for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
					shadow_screen[i] = shadow_screen[i + SCREEN_COLUMNS];
				for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
					shadow_screen[i] = {shadow_attr, tmtw_pkg::BLANK_CODE};
				shadow_row = SCREEN_ROWS - 1;
			end
		end else if (word.cell_index < CELL_COUNT) begin
			res.cell_data = shadow_screen[word.cell_index];
		end
		res.cursor_position = tmtw_pkg::POSITION_W'(shadow_row * SCREEN_COLUMNS + shadow_col);
		return res;
	endfunction

	// Mostly text with some newlines, plus reads near the cursor, anywhere, and off screen.
	function automatic tmtw_pkg::item_t random_word();
		tmtw_pkg::item_t word;
		int unsigned     pick;
		int unsigned     near;
		word.action     = tmtw_pkg::ACTION_PUT;
		word.char_byte  = tmtw_pkg::CHAR_W'($urandom);
		word.cell_index = tmtw_pkg::INDEX_W'($urandom);
		pick = $urandom_range(99);
		near = shadow_row * SCREEN_COLUMNS + shadow_col;
		if (pick < 8) begin
			word.char_byte = tmtw_pkg::NEWLINE_CODE;
		end else if (pick >= 62) begin
			word.action = tmtw_pkg::ACTION_READ;
			if (pick < 74)
				word.cell_index = tmtw_pkg::INDEX_W'(near >= 3 ? near - $urandom_range(3) : near);
			else if (pick < 95)
				word.cell_index = tmtw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1));
			else
				word.cell_index = tmtw_pkg::INDEX_W'($urandom_range(2047, CELL_COUNT));
		end
		return word;
	endfunction

	// Offer one word, idling first at the current rate, and hold until it is taken.
	task automatic offer_item(input tmtw_pkg::item_t word, input logic pinned,
			input tmtw_pkg::result_t value);
		if ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		pin_plan.push_back('{pinned, value});
		item_ch.valid <= 1'b1;
		item_ch.data  <= word;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// Drain, let any scroll finish, then write the attribute register.
	task automatic write_attribute(input tmtw_pkg::attr_t value);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random(input int unsigned count, input logic with_pressure);
		for (int n = 0; n < count; n++) begin
			// stall the output for a long stretch so the block backs up
			if (with_pressure && n == 0)
				hold_requests <= hold_requests + 1;
			// pause the input until every result is back
			if (with_pressure && n == count / 2) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
				while (awaited_results.size() != 0) @(posedge clk);
			end
			offer_item(random_word(), 1'b0, '0);
		end
	endtask

	// Drive result ready: long hold on request, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_taken != hold_requests) begin
			hold_taken      <= hold_requests;
			hold_left       <= LONG_HOLD;
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left       <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Check results, predict accepted words, track attribute writes.
	always @(posedge clk) begin
		tmtw_pkg::result_t want;
		tmtw_pkg::result_t guess;
		pin_t              plan;
		if (arst_n) begin
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (awaited_results.size() == 0) begin
					$error("result word with no expectation: cursor_position %0d cell_data %h",
						result_ch.data.cursor_position, result_ch.data.cell_data);
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					if (result_ch.data.cursor_position !== want.cursor_position) begin
						$error("cursor_position expected %0d got %0d",
							want.cursor_position, result_ch.data.cursor_position);
						error_count++;
					end
					if (result_ch.data.cell_data !== want.cell_data) begin
						$error("cell_data expected %h got %h",
							want.cell_data, result_ch.data.cell_data);
						error_count++;
					end
				end
			end
			if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
				guess = apply_to_shadow_screen(item_ch.data);
				plan  = pin_plan.pop_front();
				awaited_results.push_back(plan.pinned ? plan.value : guess);
			end
			if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
				shadow_attr = cfg_ch.data;
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CELL_COUNT; i++)
			shadow_screen[i] = {tmtw_pkg::RESET_ATTR, tmtw_pkg::BLANK_CODE};
		shadow_row      = 0;
		shadow_col      = 0;
		shadow_attr     = tmtw_pkg::RESET_ATTR;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		result_ch.ready = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// walk the opening script at the reset attribute
		for (int r = 0; r < SCRIPT_LEN; r++)
			for (int c = 0; c < OPENING_SCRIPT[r].copies; c++)
				offer_item(OPENING_SCRIPT[r].word, OPENING_SCRIPT[r].pinned,
					OPENING_SCRIPT[r].value);

		// sender idles lightly, receiver heavily
		write_attribute(8'h00);
		run_random(300, 1'b0);

		// the other way round
		write_attribute(8'hFF);
		tx_idle_pct <= 84;
		rx_idle_pct <= 25;
		run_random(300, 1'b0);

		// no idling, with a long output stall and a full drain pause
		write_attribute(tmtw_pkg::ATTR_W'($urandom));
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		run_random(300, 1'b1);

		// wait out the last results and any scroll still running
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: text_mode_terminal_writer_core.f
rtl/tmtw_pkg.sv
rtl/tmtw_chan.sv
rtl/text_mode_terminal_writer_core.sv
dv/text_mode_terminal_writer_core_test.sv
